FILE: src/radix_node48_child_table_core_assert.svh
// assertion macros for the node48 child table checker
// expects clock and reset in the scope of each use
`ifndef RADIX_NODE48_CHILD_TABLE_CORE_ASSERT_SVH
`define RADIX_NODE48_CHILD_TABLE_CORE_ASSERT_SVH

// same-cycle implication
`define RN48_CHECK_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RN48_CHECK_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/rn48_pkg.sv
// shared constants, codes and controller/datapath structs of the node48 child table
// no dependencies
package rn48_pkg;

   localparam int SLOTS       = 48;
   localparam int KEY_SPACE   = 256;
   localparam int CHILD_WIDTH = 64;

   localparam int OP_W       = 3;
   localparam int KEY_BITS   = 8;
   localparam int EXT_W      = KEY_BITS + 1;
   localparam int CHILD_BITS = 64;
   localparam int CNT_W      = 6;
   localparam int STATUS_W   = 2;
   localparam int KEY_W      = $clog2(KEY_SPACE);
   localparam int WALK_W     = KEY_W + 1;
   localparam int SLOT_AW    = $clog2(SLOTS);

   localparam logic [OP_W-1:0] OP_PUT     = 3'd0;
   localparam logic [OP_W-1:0] OP_DELETE  = 3'd1;
   localparam logic [OP_W-1:0] OP_LOCATE  = 3'd2;
   localparam logic [OP_W-1:0] OP_REPLACE = 3'd3;
   localparam logic [OP_W-1:0] OP_SCAN    = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd3;

   typedef struct packed {
      logic load;
      logic decide;
      logic loc_reply;
      logic shift;
      logic renum;
      logic del_finish;
      logic scan;
      logic scan_finish;
   } cmd_type;

   typedef struct packed {
      logic is_scan;
      logic need_locate;
      logic need_delete;
      logic shift_done;
      logic renum_done;
      logic scan_done;
   } stat_type;

endpackage

FILE: src/radix_node48_child_table_core.sv
// top level of the node48 child table: sequencer plus datapath
// depends on rn48_pkg, rn48_ctrl, rn48_dpath
//
// channel   direction  transfer
// req_*     in         start high while busy low
// rsp_*     out        rsp_valid high for one cycle, no back-pressure
//
// put, replace, undefined ops and all error cases: result registered from the decide state
// locate: result taken from the extra child slot ram read after the decide state
// delete: result after the slot shift and the one-entry-per-cycle renumber walk
//   over the index ram
// scan: results follow the descending walk from range_high down to range_low,
//   one index ram read per key
// synchronous reset clears the index valid bits and the child count at once
// start is ignored while busy; the receiver cannot stall results
module radix_node48_child_table_core
   import rn48_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [OP_W-1:0]       req_op,
   input  logic [KEY_BITS-1:0]   req_key_byte,
   input  logic [CHILD_BITS-1:0] req_child_value,
   input  logic [KEY_BITS-1:0]   req_range_low,
   input  logic [KEY_BITS-1:0]   req_range_high,
   output logic                  rsp_valid,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic                  rsp_found,
   output logic [KEY_BITS-1:0]   rsp_key_out,
   output logic [CHILD_BITS-1:0] rsp_child_out,
   output logic [CNT_W-1:0]      rsp_child_count,
   output logic                  rsp_last
);

   cmd_type  cmd;
   stat_type stat;

   rn48_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   rn48_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_op          (req_op),
      .req_key_byte    (req_key_byte),
      .req_child_value (req_child_value),
      .req_range_low   (req_range_low),
      .req_range_high  (req_range_high),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_found       (rsp_found),
      .rsp_key_out     (rsp_key_out),
      .rsp_child_out   (rsp_child_out),
      .rsp_child_count (rsp_child_count),
      .rsp_last        (rsp_last)
   );

endmodule

FILE: src/rn48_ram.sv
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module rn48_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/rn48_ctrl.sv
// operation sequencer of the node48 child table
// depends on rn48_pkg for the command and status structs
module rn48_ctrl
   import rn48_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_LOOKUP = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_LOCREP = 3'd3;
   localparam logic [2:0] ST_SHIFT  = 3'd4;
   localparam logic [2:0] ST_RENUM  = 3'd5;
   localparam logic [2:0] ST_SCAN   = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = stat.is_scan ? ST_SCAN : ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            priority if (stat.need_locate) begin
               state_in = ST_LOCREP;
            end else if (stat.need_delete) begin
               state_in = ST_SHIFT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_LOCREP: begin
            cmd.loc_reply = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_SHIFT: begin
            cmd.shift = 1'b1;
            if (stat.shift_done) begin
               state_in = ST_RENUM;
            end
         end
         ST_RENUM: begin
            if (stat.renum_done) begin
               cmd.del_finish = 1'b1;
               state_in       = ST_IDLE;
            end else begin
               cmd.renum = 1'b1;
            end
         end
         ST_SCAN: begin
            if (stat.scan_done) begin
               cmd.scan_finish = 1'b1;
               state_in        = ST_IDLE;
            end else begin
               cmd.scan = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

FILE: src/rn48_dpath.sv
// datapath of the node48 child table: key index, child slots, walk counters, result register
// depends on rn48_pkg and rn48_ram
module rn48_dpath
   import rn48_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [OP_W-1:0]       req_op,
   input  logic [KEY_BITS-1:0]   req_key_byte,
   input  logic [CHILD_BITS-1:0] req_child_value,
   input  logic [KEY_BITS-1:0]   req_range_low,
   input  logic [KEY_BITS-1:0]   req_range_high,
   input  cmd_type               cmd,
   output stat_type              stat,
   output logic                  rsp_valid,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic                  rsp_found,
   output logic [KEY_BITS-1:0]   rsp_key_out,
   output logic [CHILD_BITS-1:0] rsp_child_out,
   output logic [CNT_W-1:0]      rsp_child_count,
   output logic                  rsp_last
);

   // request registers
   logic [OP_W-1:0]        op_ff;
   logic [KEY_BITS-1:0]    key_ff;
   logic [CHILD_WIDTH-1:0] child_ff;
   logic [KEY_BITS-1:0]    lo_ff;
   logic                   in_range_ff, in_range_in;

   // node state
   logic [KEY_SPACE-1:0]   valid_ff, valid_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [SLOT_AW-1:0]     del_slot_ff, del_slot_in;

   // slot shift
   logic [CNT_W-1:0]       sh_rd_ff, sh_rd_in;
   logic                   sh_pend_ff, sh_pend_in;
   logic [SLOT_AW-1:0]     sh_wa_ff, sh_wa_in;
   logic [CNT_W-1:0]       sh_prev;
   logic                   sh_issue;

   // index walk, shared by renumber and scan
   logic [WALK_W-1:0]      walk_ff, walk_in;
   logic                   rn_pend_ff, rn_pend_in;
   logic                   rn_v_ff, rn_v_in;
   logic [KEY_W-1:0]       rn_addr_ff;
   logic                   rn_issue;
   logic                   run_ff, run_in;
   logic                   a_v_ff, a_v_in;
   logic [KEY_BITS-1:0]    a_key_ff;
   logic                   b_v_ff;
   logic [KEY_BITS-1:0]    b_key_ff;
   logic                   pend_v_ff, pend_v_in;
   logic [KEY_BITS-1:0]    pend_key_ff;
   logic [CHILD_WIDTH-1:0] pend_child_ff;

   // result register
   logic                   rsp_valid_ff, emit;
   logic [STATUS_W-1:0]    rsp_status_ff, r_status;
   logic                   rsp_found_ff, r_found;
   logic [KEY_BITS-1:0]    rsp_key_ff, r_key;
   logic [CHILD_WIDTH-1:0] rsp_child_ff, r_child;
   logic [CNT_W-1:0]       rsp_count_ff;
   logic                   rsp_last_ff, r_last;

   // ram ports
   logic                   idx_we;
   logic [KEY_W-1:0]       idx_waddr, idx_raddr;
   logic [SLOT_AW-1:0]     idx_wdata, idx_rdata;
   logic                   ch_we;
   logic [SLOT_AW-1:0]     ch_waddr, ch_raddr;
   logic [CHILD_WIDTH-1:0] ch_wdata, ch_rdata;

   logic [EXT_W-1:0]       hi_ext, hi_c;
   logic [KEY_W-1:0]       key_ix;
   logic                   present;

   assign hi_ext  = {1'b0, req_range_high};
   assign hi_c    = (hi_ext > EXT_W'(KEY_SPACE - 1)) ? EXT_W'(KEY_SPACE - 1) : hi_ext;
   assign in_range_in = ({1'b0, req_key_byte} < EXT_W'(KEY_SPACE));
   assign key_ix  = key_ff[KEY_W-1:0];
   assign present = in_range_ff && valid_ff[key_ix];

   assign sh_issue = cmd.shift && (sh_rd_ff < cnt_ff);
   assign sh_prev  = sh_rd_ff - CNT_W'(1);
   assign rn_issue = cmd.renum && (walk_ff < WALK_W'(KEY_SPACE));

   assign idx_raddr = (cmd.renum || cmd.scan) ? walk_ff[KEY_W-1:0] : key_ix;
   assign ch_raddr  = cmd.shift ? sh_rd_ff[SLOT_AW-1:0] : idx_rdata;

   always_comb begin
      valid_in    = valid_ff;
      cnt_in      = cnt_ff;
      del_slot_in = del_slot_ff;
      sh_rd_in    = sh_rd_ff;
      sh_pend_in  = sh_issue;
      sh_wa_in    = sh_prev[SLOT_AW-1:0];
      walk_in     = walk_ff;
      rn_pend_in  = rn_issue;
      rn_v_in     = rn_issue && valid_ff[walk_ff[KEY_W-1:0]];
      run_in      = run_ff;
      a_v_in      = cmd.scan && run_ff && valid_ff[walk_ff[KEY_W-1:0]];
      pend_v_in   = pend_v_ff;
      idx_we      = 1'b0;
      idx_waddr   = rn_addr_ff;
      idx_wdata   = idx_rdata - SLOT_AW'(1);
      ch_we       = 1'b0;
      ch_waddr    = idx_rdata;
      ch_wdata    = child_ff;
      emit        = 1'b0;
      r_status    = STATUS_OK;
      r_found     = 1'b0;
      r_key       = key_ff;
      r_child     = '0;
      r_last      = 1'b1;

      if (cmd.load) begin
         walk_in   = WALK_W'(hi_c);
         run_in    = (req_op == OP_SCAN) && ({1'b0, req_range_low} <= hi_c);
         pend_v_in = 1'b0;
      end

      if (cmd.decide) begin
         unique case (op_ff)
            OP_PUT: begin
               emit = 1'b1;
               priority if (!in_range_ff) begin
                  r_status = STATUS_ABSENT;
               end else if (present) begin
                  ch_we   = 1'b1;
                  r_found = 1'b1;
                  r_child = child_ff;
               end else if (cnt_ff >= CNT_W'(SLOTS)) begin
                  r_status = STATUS_FULL;
               end else begin
                  idx_we           = 1'b1;
                  idx_waddr        = key_ix;
                  idx_wdata        = cnt_ff[SLOT_AW-1:0];
                  valid_in[key_ix] = 1'b1;
                  ch_we            = 1'b1;
                  ch_waddr         = cnt_ff[SLOT_AW-1:0];
                  cnt_in           = cnt_ff + CNT_W'(1);
                  r_found          = 1'b1;
                  r_child          = child_ff;
               end
            end
            OP_DELETE: begin
               priority if (cnt_ff == '0) begin
                  emit     = 1'b1;
                  r_status = STATUS_EMPTY;
               end else if (!present) begin
                  emit     = 1'b1;
                  r_status = STATUS_ABSENT;
               end else begin
                  valid_in[key_ix] = 1'b0;
                  del_slot_in      = idx_rdata;
                  sh_rd_in         = CNT_W'(idx_rdata) + CNT_W'(1);
                  walk_in          = '0;
               end
            end
            OP_LOCATE: begin
               if (!present) begin
                  emit     = 1'b1;
                  r_status = STATUS_ABSENT;
               end
            end
            OP_REPLACE: begin
               emit = 1'b1;
               if (present) begin
                  ch_we   = 1'b1;
                  r_found = 1'b1;
                  r_child = child_ff;
               end else begin
                  r_status = STATUS_ABSENT;
               end
            end
            default: begin
               emit = 1'b1;
            end
         endcase
      end

      if (cmd.loc_reply) begin
         emit    = 1'b1;
         r_found = 1'b1;
         r_child = ch_rdata;
      end

      // slot shift write stage
      if (sh_issue) begin
         sh_rd_in = sh_rd_ff + CNT_W'(1);
      end
      if (sh_pend_ff) begin
         ch_we    = 1'b1;
         ch_waddr = sh_wa_ff;
         ch_wdata = ch_rdata;
      end

      // renumber write stage
      if (rn_issue) begin
         walk_in = walk_ff + WALK_W'(1);
      end
      if (rn_pend_ff && rn_v_ff && (idx_rdata > del_slot_ff)) begin
         idx_we    = 1'b1;
         idx_waddr = rn_addr_ff;
         idx_wdata = idx_rdata - SLOT_AW'(1);
      end

      if (cmd.del_finish) begin
         cnt_in = cnt_ff - CNT_W'(1);
         emit   = 1'b1;
      end

      // descending scan
      if (cmd.scan && run_ff) begin
         if (EXT_W'(walk_ff) == {1'b0, lo_ff}) begin
            run_in = 1'b0;
         end else begin
            walk_in = walk_ff - WALK_W'(1);
         end
      end
      if (b_v_ff) begin
         pend_v_in = 1'b1;
         if (pend_v_ff) begin
            emit    = 1'b1;
            r_found = 1'b1;
            r_key   = pend_key_ff;
            r_child = pend_child_ff;
            r_last  = 1'b0;
         end
      end
      if (cmd.scan_finish) begin
         emit = 1'b1;
         if (pend_v_ff) begin
            r_found = 1'b1;
            r_key   = pend_key_ff;
            r_child = pend_child_ff;
         end else begin
            r_key = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         cnt_ff       <= '0;
         sh_pend_ff   <= 1'b0;
         rn_pend_ff   <= 1'b0;
         run_ff       <= 1'b0;
         a_v_ff       <= 1'b0;
         b_v_ff       <= 1'b0;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         cnt_ff       <= cnt_in;
         sh_pend_ff   <= sh_pend_in;
         rn_pend_ff   <= rn_pend_in;
         run_ff       <= run_in;
         a_v_ff       <= a_v_in;
         b_v_ff       <= a_v_ff;
         pend_v_ff    <= pend_v_in;
         rsp_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff       <= req_op;
         key_ff      <= req_key_byte;
         child_ff    <= req_child_value[CHILD_WIDTH-1:0];
         lo_ff       <= req_range_low;
         in_range_ff <= in_range_in;
      end
      del_slot_ff <= del_slot_in;
      sh_rd_ff    <= sh_rd_in;
      sh_wa_ff    <= sh_wa_in;
      walk_ff     <= walk_in;
      rn_v_ff     <= rn_v_in;
      rn_addr_ff  <= walk_ff[KEY_W-1:0];
      a_key_ff    <= KEY_BITS'(walk_ff);
      b_key_ff    <= a_key_ff;
      if (b_v_ff) begin
         pend_key_ff   <= b_key_ff;
         pend_child_ff <= ch_rdata;
      end
      if (emit) begin
         rsp_status_ff <= r_status;
         rsp_found_ff  <= r_found;
         rsp_key_ff    <= r_key;
         rsp_child_ff  <= r_child;
         rsp_count_ff  <= cnt_in;
         rsp_last_ff   <= r_last;
      end
   end

   rn48_ram #(
      .WIDTH (SLOT_AW),
      .DEPTH (KEY_SPACE)
   ) u_index_ram (
      .clock (clock),
      .we    (idx_we),
      .waddr (idx_waddr),
      .wdata (idx_wdata),
      .raddr (idx_raddr),
      .rdata (idx_rdata)
   );

   rn48_ram #(
      .WIDTH (CHILD_WIDTH),
      .DEPTH (SLOTS)
   ) u_child_ram (
      .clock (clock),
      .we    (ch_we),
      .waddr (ch_waddr),
      .wdata (ch_wdata),
      .raddr (ch_raddr),
      .rdata (ch_rdata)
   );

   assign stat.is_scan     = (op_ff == OP_SCAN);
   assign stat.need_locate = (op_ff == OP_LOCATE) && present;
   assign stat.need_delete = (op_ff == OP_DELETE) && (cnt_ff != '0) && present;
   assign stat.shift_done  = !sh_issue && !sh_pend_ff;
   assign stat.renum_done  = (walk_ff >= WALK_W'(KEY_SPACE)) && !rn_pend_ff;
   assign stat.scan_done   = !run_ff && !a_v_ff && !b_v_ff;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_key_out     = rsp_key_ff;
   assign rsp_child_out   = CHILD_BITS'(rsp_child_ff);
   assign rsp_child_count = rsp_count_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

FILE: src/rn48_checker.sv
// port-level assertions for the node48 child table, bound to the top level
// depends on rn48_pkg and radix_node48_child_table_core_assert.svh
`include "radix_node48_child_table_core_assert.svh"

module rn48_checker
   import rn48_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                rsp_valid,
   input logic [STATUS_W-1:0] rsp_status,
   input logic                rsp_found,
   input logic [CNT_W-1:0]    rsp_child_count,
   input logic                rsp_last
);

   `RN48_CHECK_IMP(a_found_ok, rsp_valid && rsp_found, rsp_status == STATUS_OK, "found without ok")
   `RN48_CHECK_IMP(a_full_count, rsp_valid && (rsp_status == STATUS_FULL), rsp_child_count == CNT_W'(SLOTS), "full with short count")
   `RN48_CHECK_NXT(a_accept_busy, start && !busy, busy, "transfer did not raise busy")
   `RN48_CHECK_NXT(a_last_gap, rsp_valid && rsp_last, !rsp_valid, "result right after last")

endmodule

bind radix_node48_child_table_core rn48_checker u_rn48_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_status      (rsp_status),
   .rsp_found       (rsp_found),
   .rsp_child_count (rsp_child_count),
   .rsp_last        (rsp_last)
);

FILE: sim/tb_radix_node48_child_table_core.sv
`timescale 1ns / 100ps
// self-checking bench for radix_node48_child_table_core: directed and random node traffic,
// every result compared with a bench-side model of the key index and the child slots
// depends on rn48_pkg and the core rtl
module tb_radix_node48_child_table_core;
   import rn48_pkg::*;

   localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
   localparam int IDLE_LIMIT   = 5000;
   localparam int DRAIN_CYCLES = 400;
   localparam int REPORT_MAX   = 10;

   typedef struct {
      logic [OP_W-1:0]       op;
      logic [KEY_BITS-1:0]   key;
      logic [CHILD_BITS-1:0] child;
      logic [KEY_BITS-1:0]   lo;
      logic [KEY_BITS-1:0]   hi;
   } node_req_type;

   typedef struct {
      logic [STATUS_W-1:0]   status;
      logic                  found;
      logic [KEY_BITS-1:0]   key;
      logic [CHILD_BITS-1:0] child;
      logic [CNT_W-1:0]      count;
      logic                  last;
   } node_rsp_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [OP_W-1:0]       req_op = '0;
   logic [KEY_BITS-1:0]   req_key_byte = '0;
   logic [CHILD_BITS-1:0] req_child_value = '0;
   logic [KEY_BITS-1:0]   req_range_low = '0;
   logic [KEY_BITS-1:0]   req_range_high = '0;
   logic                  rsp_valid;
   logic [STATUS_W-1:0]   rsp_status;
   logic                  rsp_found;
   logic [KEY_BITS-1:0]   rsp_key_out;
   logic [CHILD_BITS-1:0] rsp_child_out;
   logic [CNT_W-1:0]      rsp_child_count;
   logic                  rsp_last;

   radix_node48_child_table_core dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_key_byte    (req_key_byte),
      .req_child_value (req_child_value),
      .req_range_low   (req_range_low),
      .req_range_high  (req_range_high),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_found       (rsp_found),
      .rsp_key_out     (rsp_key_out),
      .rsp_child_out   (rsp_child_out),
      .rsp_child_count (rsp_child_count),
      .rsp_last        (rsp_last)
   );

   node_req_type pending_reqs[$];
   node_rsp_type expected_rsps[$];
   node_req_type drive_req;
   logic         took = 1'b0;
   int           gap_left = 0;
   int           calm_left = 0;
   int           mismatches = 0;
   int           idle_cycles = 0;

   // model of the node
   logic [SLOT_AW-1:0]    idx_slot [KEY_SPACE];
   bit                    idx_live [KEY_SPACE];
   logic [CHILD_BITS-1:0] slot_child [SLOTS];
   int                    live_count = 0;

   // key occupancy as the stimulus generator sees it
   bit gen_live [KEY_SPACE];
   int gen_count = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   function automatic void push_node_result(logic [STATUS_W-1:0] status, logic found,
                                            int key, logic [CHILD_BITS-1:0] child,
                                            logic last);
      node_rsp_type r;
      r.status = status;
      r.found  = found;
      r.key    = key[KEY_BITS-1:0];
      r.child  = found ? child : '0;
      r.count  = live_count[CNT_W-1:0];
      r.last   = last;
      expected_rsps.insert(expected_rsps.size(), r);
   endfunction

   function automatic void apply_node_op(node_req_type q);
      int slot;
      int s;
      int i;
      int hits;
      int n;
      int lo_i;
      int hi_i;
      slot = idx_slot[q.key];
      lo_i = q.lo;
      hi_i = q.hi;
      case (q.op)
         OP_PUT: begin
            if (idx_live[q.key]) begin
               slot_child[slot] = q.child;
               push_node_result(STATUS_OK, 1'b1, q.key, q.child, 1'b1);
            end else if (live_count >= SLOTS) begin
               push_node_result(STATUS_FULL, 1'b0, q.key, '0, 1'b1);
            end else begin
               idx_slot[q.key] = live_count[SLOT_AW-1:0];
               idx_live[q.key] = 1'b1;
               slot_child[live_count] = q.child;
               live_count++;
               push_node_result(STATUS_OK, 1'b1, q.key, q.child, 1'b1);
            end
         end
         OP_DELETE: begin
            if (live_count == 0) begin
               push_node_result(STATUS_EMPTY, 1'b0, q.key, '0, 1'b1);
            end else if (!idx_live[q.key]) begin
               push_node_result(STATUS_ABSENT, 1'b0, q.key, '0, 1'b1);
            end else begin
               idx_live[q.key] = 1'b0;
               idx_slot[q.key] = '0;
               for (s = slot; s + 1 < live_count; s++) slot_child[s] = slot_child[s + 1];
               live_count--;
               for (i = 0; i < KEY_SPACE; i++) begin
                  if (idx_live[i] && idx_slot[i] > slot) idx_slot[i]--;
               end
               push_node_result(STATUS_OK, 1'b0, q.key, '0, 1'b1);
            end
         end
         OP_LOCATE: begin
            if (idx_live[q.key]) push_node_result(STATUS_OK, 1'b1, q.key, slot_child[slot], 1'b1);
            else push_node_result(STATUS_ABSENT, 1'b0, q.key, '0, 1'b1);
         end
         OP_REPLACE: begin
            if (idx_live[q.key]) begin
               slot_child[slot] = q.child;
               push_node_result(STATUS_OK, 1'b1, q.key, q.child, 1'b1);
            end else begin
               push_node_result(STATUS_ABSENT, 1'b0, q.key, '0, 1'b1);
            end
         end
         OP_SCAN: begin
            hits = 0;
            for (i = hi_i; i >= lo_i; i--) if (idx_live[i]) hits++;
            if (hits == 0) begin
               push_node_result(STATUS_OK, 1'b0, 0, '0, 1'b1);
            end else begin
               n = 0;
               for (i = hi_i; i >= lo_i; i--) begin
                  if (idx_live[i]) begin
                     n++;
                     push_node_result(STATUS_OK, 1'b1, i, slot_child[idx_slot[i]], n == hits);
                  end
               end
            end
         end
         default: push_node_result(STATUS_OK, 1'b0, q.key, '0, 1'b1);
      endcase
   endfunction

   function automatic void add_req(logic [OP_W-1:0] op, int key, logic [CHILD_BITS-1:0] child,
                                   int lo, int hi);
      node_req_type q;
      q.op    = op;
      q.key   = key[KEY_BITS-1:0];
      q.child = child;
      q.lo    = lo[KEY_BITS-1:0];
      q.hi    = hi[KEY_BITS-1:0];
      pending_reqs.insert(pending_reqs.size(), q);
      if (op == OP_PUT && !gen_live[key] && gen_count < SLOTS) begin
         gen_live[key] = 1'b1;
         gen_count++;
      end
      if (op == OP_DELETE && gen_live[key]) begin
         gen_live[key] = 1'b0;
         gen_count--;
      end
   endfunction

   function automatic int pick_live_key();
      int k;
      int n;
      if (gen_count == 0) return $urandom_range(0, KEY_SPACE - 1);
      n = $urandom_range(0, gen_count - 1);
      for (k = 0; k < KEY_SPACE; k++) begin
         if (gen_live[k]) begin
            if (n == 0) return k;
            n--;
         end
      end
      return 0;
   endfunction

   function automatic int pick_free_key();
      int k;
      k = $urandom_range(0, KEY_SPACE - 1);
      while (gen_live[k]) k = $urandom_range(0, KEY_SPACE - 1);
      return k;
   endfunction

   function automatic logic [CHILD_BITS-1:0] rand_child();
      int r;
      r = $urandom_range(0, 15);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [OP_W-1:0] rand_op();
      return OP_W'($urandom_range(0, 4));
   endfunction

   function automatic void add_random_req(logic [OP_W-1:0] op);
      int key;
      int lo;
      int hi;
      int live_pct;
      live_pct = (op == OP_PUT) ? 10 : 85;
      key = ($urandom_range(0, 99) < live_pct) ? pick_live_key()
                                               : $urandom_range(0, KEY_SPACE - 1);
      lo = $urandom_range(0, KEY_SPACE - 1);
      hi = $urandom_range(0, KEY_SPACE - 1);
      if ($urandom_range(0, 3) == 0) begin
         lo = 0;
         hi = KEY_SPACE - 1;
      end
      add_req(op, key, rand_child(), lo, hi);
   endfunction

   function automatic int pick_gap();
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 5) begin
         calm_left = $urandom_range(10, 30);
         return 0;
      end
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // stimulus and end of run
   initial begin
      add_req(OP_DELETE, 0, '0, 0, 0);
      add_req(OP_LOCATE, 255, '1, 255, 255);
      add_req(OP_REPLACE, 17, '1, 0, 0);
      add_req(OP_SCAN, 0, '0, 0, 255);
      add_req(OP_PUT, 0, '1, 0, 0);
      add_req(OP_PUT, 255, '0, 255, 255);
      add_req(OP_PUT, 128, 64'h5555_5555_5555_5555, 0, 0);
      add_req(OP_PUT, 0, 64'hAAAA_AAAA_AAAA_AAAA, 0, 0);
      add_req(OP_LOCATE, 0, '0, 0, 0);
      add_req(OP_LOCATE, 255, '0, 0, 0);
      add_req(OP_REPLACE, 255, '1, 0, 0);
      add_req(OP_SCAN, 0, '0, 0, 255);
      add_req(OP_SCAN, 0, '0, 200, 100);
      add_req(OP_SCAN, 0, '0, 128, 128);
      add_req(OP_DELETE, 7, '0, 0, 0);
      add_req(OP_DELETE, 0, '0, 0, 0);
      add_req(OP_LOCATE, 128, '0, 0, 0);
      add_req(OP_LOCATE, 255, '0, 0, 0);
      add_req(OP_SPARE_LO, 9, '1, 255, 0);
      add_req(OP_SPARE_HI, 255, '1, 0, 255);
      add_req(OP_SCAN, 0, '0, 0, 255);

      // fill to capacity, then hit the full node
      while (gen_count < SLOTS) add_random_req(($urandom_range(0, 7) == 0) ? rand_op() : OP_PUT);
      repeat (3) add_req(OP_PUT, pick_free_key(), rand_child(), 0, 0);
      add_req(OP_SCAN, 0, '0, 0, 255);
      repeat (8) add_random_req(rand_op());
      // drain to empty, then delete on the empty node
      while (gen_count > 0) add_random_req(($urandom_range(0, 7) == 0) ? rand_op() : OP_DELETE);
      repeat (2) add_req(OP_DELETE, $urandom_range(0, KEY_SPACE - 1), rand_child(), 0, 0);
      repeat (6) add_random_req(rand_op());

      while (pending_reqs.size() != 0 || start || expected_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || took) begin
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            drive_req = pending_reqs.pop_front();
            req_op          <= drive_req.op;
            req_key_byte    <= drive_req.key;
            req_child_value <= drive_req.child;
            req_range_low   <= drive_req.lo;
            req_range_high  <= drive_req.hi;
            start           <= 1'b1;
            gap_left = pick_gap();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // request transfer
   always @(posedge clock) begin
      if (reset) begin
         took <= 1'b0;
      end else begin
         took <= start && !busy;
         if (start && !busy) apply_node_op(drive_req);
      end
   end

   // result monitor and watchdog
   always @(posedge clock) begin
      node_rsp_type want;
      if (!reset) begin
         if ((start && !busy) || rsp_valid) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
         end else if (rsp_valid) begin
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("unexpected result: status=%0d found=%0d key=%0d child=%h count=%0d last=%0d",
                           rsp_status, rsp_found, rsp_key_out, rsp_child_out, rsp_child_count,
                           rsp_last);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_status !== want.status || rsp_found !== want.found ||
                   rsp_key_out !== want.key || rsp_child_out !== want.child ||
                   rsp_child_count !== want.count || rsp_last !== want.last) begin
                  mismatches++;
                  if (mismatches <= REPORT_MAX) begin
                     $display("mismatch exp: status=%0d found=%0d key=%0d child=%h count=%0d last=%0d",
                              want.status, want.found, want.key, want.child, want.count,
                              want.last);
                     $display("         got: status=%0d found=%0d key=%0d child=%h count=%0d last=%0d",
                              rsp_status, rsp_found, rsp_key_out, rsp_child_out,
                              rsp_child_count, rsp_last);
                  end
               end
            end
         end
      end
   end

endmodule

FILE: radix_node48_child_table_core.f
+incdir+src
src/rn48_pkg.sv
src/rn48_ram.sv
src/rn48_ctrl.sv
src/rn48_dpath.sv
src/radix_node48_child_table_core.sv
src/rn48_checker.sv
sim/tb_radix_node48_child_table_core.sv
